[rtl/core/alpha_flash_envelope_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for alpha_flash_envelope_top
// Clocked implication checks, reset-qualified, used by the afe_checker file.
// ----------------------------------------------------------------------------
`ifndef ALPHA_FLASH_ENVELOPE_TOP_MACROS_SVH
`define ALPHA_FLASH_ENVELOPE_TOP_MACROS_SVH

// same-cycle implication
`define AFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alpha flash envelope check failed");

// next-cycle implication
`define AFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alpha flash envelope check failed");

`endif

[rtl/core/afe_pkg.sv]
// ----------------------------------------------------------------------------
// afe_pkg
// Shared constants, register indexes and item types of the alpha flash block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afe_pkg;

  localparam int FRAME_WIDTH = 32;
  // phase compares need one bit over both the phase and the 9-bit ramp end
  localparam int CMP_W       = FRAME_WIDTH + 1;

  localparam logic [7:0] FULL_ALPHA  = 8'hFF;
  localparam logic [7:0] MODE_FIXED  = 8'hA5;

  localparam logic [31:0] EVENT_TAG_RST    = 32'h0000_0000;
  localparam logic [7:0]  DOWN_FRAMES_RST  = 8'd12;
  localparam logic [7:0]  UP_FRAMES_RST    = 8'd48;
  localparam logic [7:0]  FLOOR_ALPHA_RST  = 8'h80;
  localparam logic [23:0] FLASH_COLOUR_RST = 24'h20A0FF;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_TAG    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_FRAMES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_FRAMES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_ALPHA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_COLOUR = 3'd4;

  localparam int DIV_NUM_W = 16;
  localparam int DIV_DEN_W = 8;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  typedef struct packed {
    logic [31:0] frame_count;
    logic [31:0] event_magic;
    logic [31:0] event_seq;
  } afe_in_t;

  typedef struct packed {
    logic [15:0] mode_word;
    logic [23:0] background_colour;
    logic        flash_over;
  } afe_out_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic div_start;
    logic div_sel_k;
    logic alpha_take;
    logic k_take;
    logic scale;
    logic out_load;
  } afe_cmd_t;

  typedef struct packed {
    logic running;
    logic final_frame;
    logic span_zero;
    logic div_done;
  } afe_sts_t;

endpackage

[rtl/core/afe_div.sv]
// ----------------------------------------------------------------------------
// afe_div
// Restoring divider, one quotient bit per cycle, 16-bit by 8-bit unsigned.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afe_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [afe_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [afe_pkg::DIV_DEN_W-1:0] den_i,
  output logic                          done_o,
  output logic [afe_pkg::DIV_NUM_W-1:0] quo_o
);
  import afe_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_d = {quo_q[DIV_NUM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/core/afe_dp.sv]
// ----------------------------------------------------------------------------
// afe_dp
// Datapath: configuration and flash state, phase, ramp alpha, colour scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afe_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [afe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [afe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  afe_pkg::afe_in_t               in_i,
  input  afe_pkg::afe_cmd_t              cmd_i,
  output afe_pkg::afe_sts_t              sts_o,
  output afe_pkg::afe_out_t              out_o
);
  import afe_pkg::*;

  logic [31:0] event_tag_q;
  logic [7:0]  down_q;
  logic [7:0]  up_q;
  logic [7:0]  floor_q;
  logic [23:0] colour_q;

  logic [31:0]            last_seq_q;
  logic [FRAME_WIDTH-1:0] start_q;
  logic                   running_q;

  logic [FRAME_WIDTH-1:0] phase_q;
  logic [15:0]            num_q;
  logic                   sel_down_q;
  logic [7:0]             alpha_q;
  logic [8:0]             k_q;
  afe_out_t               res_q;
  afe_out_t               out_q;

  logic [FRAME_WIDTH-1:0] frame;
  logic                   hit;
  logic [7:0]             span;
  logic [CMP_W-1:0]       phase_ext;
  logic [8:0]             ramp_end;
  logic                   in_down;
  logic                   in_ramp;
  logic [7:0]             n_down;
  logic [8:0]             n_up;
  logic [7:0]             n_sel;
  logic [DIV_NUM_W-1:0]   div_num;
  logic [DIV_DEN_W-1:0]   div_den;
  logic                   div_done;
  logic [DIV_NUM_W-1:0]   div_quo;
  logic [16:0]            prod_r;
  logic [16:0]            prod_g;
  logic [16:0]            prod_b;

  assign frame = in_i.frame_count[FRAME_WIDTH-1:0];
  assign hit   = (in_i.event_magic == event_tag_q) && (in_i.event_seq != last_seq_q);
  assign span  = FULL_ALPHA - floor_q;

  assign phase_ext = CMP_W'(phase_q);
  assign ramp_end  = {1'b0, down_q} + {1'b0, up_q};
  assign in_down   = phase_ext < CMP_W'(down_q);
  assign in_ramp   = phase_ext < CMP_W'(ramp_end);

  // step count into the active ramp, 1-based; both fit in a byte inside the ramp
  assign n_down = phase_q[7:0] + 8'd1;
  assign n_up   = phase_ext[8:0] - {1'b0, down_q} + 9'd1;
  assign n_sel  = in_down ? n_down : n_up[7:0];

  assign div_num = cmd_i.div_sel_k ? {FULL_ALPHA - alpha_q, 8'h00} : num_q;
  assign div_den = cmd_i.div_sel_k ? span : (sel_down_q ? down_q : up_q);

  afe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign prod_r = 17'(colour_q[7:0])   * 17'(k_q);
  assign prod_g = 17'(colour_q[15:8])  * 17'(k_q);
  assign prod_b = 17'(colour_q[23:16]) * 17'(k_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_tag_q <= EVENT_TAG_RST;
      down_q      <= DOWN_FRAMES_RST;
      up_q        <= UP_FRAMES_RST;
      floor_q     <= FLOOR_ALPHA_RST;
      colour_q    <= FLASH_COLOUR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EVENT_TAG:    event_tag_q <= cfg_data_i;
        CFG_DOWN_FRAMES:  down_q      <= cfg_data_i[7:0];
        CFG_UP_FRAMES:    up_q        <= cfg_data_i[7:0];
        CFG_FLOOR_ALPHA:  floor_q     <= cfg_data_i[7:0];
        CFG_FLASH_COLOUR: colour_q    <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q <= '0;
      start_q    <= '0;
      running_q  <= 1'b0;
    end else if (cmd_i.capture && hit) begin
      last_seq_q <= in_i.event_seq;
      start_q    <= frame;
      running_q  <= 1'b1;
    end else if (cmd_i.eval && !in_ramp) begin
      // final restoring frame ends the flash
      running_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      phase_q <= hit ? '0 : frame - start_q;
    end
    if (cmd_i.eval) begin
      num_q      <= 16'(span) * 16'(n_sel);
      sel_down_q <= in_down;
      if (!in_ramp) begin
        res_q.mode_word         <= {FULL_ALPHA, MODE_FIXED};
        res_q.background_colour <= '0;
        res_q.flash_over        <= 1'b1;
      end
    end
    if (cmd_i.alpha_take) begin
      alpha_q <= sel_down_q ? FULL_ALPHA - div_quo[7:0] : floor_q + div_quo[7:0];
      k_q     <= '0;
    end
    if (cmd_i.k_take) begin
      k_q <= div_quo[8:0];
    end
    if (cmd_i.scale) begin
      res_q.mode_word         <= {alpha_q, MODE_FIXED};
      res_q.background_colour <= {prod_b[15:8], prod_g[15:8], prod_r[15:8]};
      res_q.flash_over        <= 1'b0;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign sts_o.running     = running_q;
  assign sts_o.final_frame = !in_ramp;
  assign sts_o.span_zero   = (span == 8'd0);
  assign sts_o.div_done    = div_done;

  assign out_o = out_q;

endmodule

[rtl/core/afe_ctrl.sv]
// ----------------------------------------------------------------------------
// afe_ctrl
// Sequencer: input handshake, ramp and scale divisions, output register valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  afe_pkg::afe_sts_t  sts_i,
  output afe_pkg::afe_cmd_t  cmd_o
);
  import afe_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVAL   = 3'd1;
  localparam logic [2:0] ST_DIVA   = 3'd2;
  localparam logic [2:0] ST_DIVA_W = 3'd3;
  localparam logic [2:0] ST_DIVK   = 3'd4;
  localparam logic [2:0] ST_DIVK_W = 3'd5;
  localparam logic [2:0] ST_SCALE  = 3'd6;
  localparam logic [2:0] ST_PUSH   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // output register can take a result when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (!sts_i.running) begin
          state_d = ST_IDLE;
        end else if (sts_i.final_frame) begin
          state_d = ST_PUSH;
        end else begin
          state_d = ST_DIVA;
        end
      end
      ST_DIVA: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIVA_W;
      end
      ST_DIVA_W: begin
        if (sts_i.div_done) begin
          cmd_o.alpha_take = 1'b1;
          // no dip depth: k stays zero
          state_d = sts_i.span_zero ? ST_SCALE : ST_DIVK;
        end
      end
      ST_DIVK: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel_k = 1'b1;
        state_d         = ST_DIVK_W;
      end
      ST_DIVK_W: begin
        if (sts_i.div_done) begin
          cmd_o.k_take = 1'b1;
          state_d      = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/alpha_flash_envelope_top.sv]
// ----------------------------------------------------------------------------
// alpha_flash_envelope_top
// Alpha pulse envelope for a display flash, one item per vertical blank.
//
//   channel   direction   handshake                      payload
//   in        input       in_valid_i / in_stall_o        in_i  (afe_in_t)
//   out       output      out_valid_o / out_stall_i      out_o (afe_out_t)
//   cfg       input       cfg_we_i                       cfg_idx_i, cfg_data_i
//
// An item on a ramp frame passes through both divisions of the shared restoring
// divider, 16 steps each; when the floor alpha is 255 the scale division is
// skipped, and the final frame skips both. With no flash running an item gives
// nothing and frees the input.
// One item is in work at a time; the next is taken while a result waits.
// Reset restores register defaults and leaves the flash idle.
// A stalled result holds in the output register and blocks only the next push.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alpha_flash_envelope_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [afe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [afe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  afe_pkg::afe_in_t               in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output afe_pkg::afe_out_t              out_o
);
  import afe_pkg::*;

  afe_cmd_t cmd;
  afe_sts_t sts;

  afe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  afe_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_o      (out_o)
  );

endmodule

[rtl/core/afe_checker.sv]
// ----------------------------------------------------------------------------
// afe_checker
// Port-level checks of the alpha flash block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "alpha_flash_envelope_top_macros.svh"

module afe_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  afe_pkg::afe_out_t out_o
);
  import afe_pkg::*;

  logic out_wait;
  logic out_last;
  logic final_ok;

  assign out_wait = out_valid_o && out_stall_i;
  assign out_last = out_valid_o && out_o.flash_over;
  assign final_ok = (out_o.mode_word[15:8] == FULL_ALPHA) && (out_o.background_colour == '0);

  // a stalled result holds
  `AFE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_o))

  // an accepted item blocks the next one while it is worked
  `AFE_ASSERT_NEXT(a_in_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // mode word always carries the fixed low byte
  `AFE_ASSERT_NOW(a_mode_fixed, clk_i, rst_ni, out_valid_o, out_o.mode_word[7:0] == MODE_FIXED)

  // the restoring frame shows full alpha and black
  `AFE_ASSERT_NOW(a_final_frame, clk_i, rst_ni, out_last, final_ok)

endmodule

bind alpha_flash_envelope_top afe_checker u_afe_checker (.*);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for alpha_flash_envelope_top. A queue of vblank items
// feeds a clocked driver; a clocked monitor predicts each accepted item in
// step with the block and checks every result field against the oldest
// prediction. Registers change only with the block drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import afe_pkg::*;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  afe_in_t               in_i        = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  afe_out_t              out_o;

  alpha_flash_envelope_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // register copy and flash state of the predictor
  logic [31:0] m_tag;
  logic [7:0]  m_down;
  logic [7:0]  m_up;
  logic [7:0]  m_floor;
  logic [23:0] m_colour;
  logic [31:0] seen_seq;
  logic [31:0] flash_start;
  bit          flash_on;

  afe_in_t  vblank_q[$];
  afe_out_t shade_q[$];

  bit in_took;
  int n_in;
  int n_gen;
  int n_bad;
  int gap_left;
  int burst_left;
  int hold_left;
  int holds_done;
  int pat_left;
  int stall_max;
  int cyc;
  bit pat_stall;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit flash_predict(input afe_in_t it, output afe_out_t res);
    logic [31:0] fmask;
    logic [31:0] fr;
    logic [31:0] ph;
    logic [31:0] span;
    logic [31:0] dn;
    logic [31:0] upn;
    logic [31:0] alpha;
    logic [31:0] k;
    int b;
    fmask = 32'((64'd1 << FRAME_WIDTH) - 1);
    fr    = it.frame_count & fmask;
    res   = '0;
    if (it.event_magic == m_tag && it.event_seq != seen_seq) begin
      seen_seq    = it.event_seq;
      flash_start = fr;
      flash_on    = 1'b1;
    end
    if (!flash_on) return 1'b0;
    ph   = (fr - flash_start) & fmask;
    span = 32'(FULL_ALPHA) - 32'(m_floor);
    dn   = 32'(m_down);
    upn  = 32'(m_up);
    if (ph < dn) begin
      alpha = 32'(FULL_ALPHA) - span * (ph + 1) / dn;
    end else if (ph < dn + upn) begin
      alpha = 32'(m_floor) + span * (ph - dn + 1) / upn;
    end else begin
      // restoring frame: full alpha, black, flash over
      res.mode_word  = {FULL_ALPHA, MODE_FIXED};
      res.flash_over = 1'b1;
      flash_on       = 1'b0;
      return 1'b1;
    end
    k = (span == 0) ? 32'd0 : (32'(FULL_ALPHA) - alpha) * 256 / span;
    res.mode_word = {alpha[7:0], MODE_FIXED};
    for (b = 0; b < 3; b++)
      res.background_colour[8*b +: 8] = 8'((32'(m_colour[8*b +: 8]) * k) >> 8);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    n_bad++;
    if (n_bad <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // monitor: check results, predict accepted items
  always @(posedge clk_i) begin
    afe_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (shade_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item: mode %h colour %h over %b",
                                    out_o.mode_word, out_o.background_colour,
                                    out_o.flash_over));
        end else begin
          want = shade_q.pop_front();
          if (out_o.mode_word !== want.mode_word)
            report_mismatch($sformatf("mode_word: expected %h, got %h",
                                      want.mode_word, out_o.mode_word));
          if (out_o.background_colour !== want.background_colour)
            report_mismatch($sformatf("background_colour: expected %h, got %h",
                                      want.background_colour, out_o.background_colour));
          if (out_o.flash_over !== want.flash_over)
            report_mismatch($sformatf("flash_over: expected %b, got %b",
                                      want.flash_over, out_o.flash_over));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        in_took = 1'b1;
        n_in++;
        if (flash_predict(in_i, want)) shade_q.push_back(want);
      end
    end
  end

  // driver: bursts of items with random gaps between them
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_took) begin
        if (gap_left != 0 || vblank_q.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          in_i       <= vblank_q.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
          end
        end
      end
      in_took = 1'b0;
    end
  end

  // receiver: stall pattern, plus two long holds to back up the block
  always @(negedge clk_i) begin
    if (rst_ni) begin
      cyc++;
      if (cyc % 700 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_max = 0;
          1:       stall_max = 3;
          default: stall_max = 12;
        endcase
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (holds_done < 2 && n_in >= 700 * (holds_done + 1)) begin
        hold_left = 400;
        holds_done++;
        out_stall_i <= 1'b1;
      end else begin
        if (pat_left == 0) begin
          pat_stall = (stall_max != 0) && !pat_stall;
          pat_left  = pat_stall ? $urandom_range(1, stall_max) : $urandom_range(1, 16);
        end
        pat_left--;
        out_stall_i <= pat_stall;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_EVENT_TAG:    m_tag    = val;
      CFG_DOWN_FRAMES:  m_down   = val[7:0];
      CFG_UP_FRAMES:    m_up     = val[7:0];
      CFG_FLOOR_ALPHA:  m_floor  = val[7:0];
      CFG_FLASH_COLOUR: m_colour = val[23:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every item is taken and every result is in, then let it settle
  task automatic drain();
    do @(negedge clk_i);
    while (vblank_q.size() != 0 || in_valid_i || shade_q.size() != 0);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic set_flash(input logic [31:0] tag, input logic [7:0] dn,
                           input logic [7:0] upn, input logic [7:0] fl,
                           input logic [23:0] col);
    logic [31:0] junk;
    drain();
    junk = $urandom();
    write_reg(CFG_EVENT_TAG, tag);
    write_reg(CFG_DOWN_FRAMES, {junk[31:8], dn});
    write_reg(CFG_UP_FRAMES, {junk[23:0], upn});
    write_reg(CFG_FLOOR_ALPHA, {junk[15:0], junk[31:24], fl});
    write_reg(CFG_FLASH_COLOUR, {junk[7:0], col});
  endtask

  task automatic push_vb(input logic [31:0] fr, input logic [31:0] mg,
                         input logic [31:0] sq);
    afe_in_t it;
    it.frame_count = fr;
    it.event_magic = mg;
    it.event_seq   = sq;
    vblank_q.push_back(it);
    n_gen++;
  endtask

  // one flash: trigger, then consecutive frames with the event still buffered
  task automatic flash_run(input int len);
    logic [31:0] fr;
    logic [31:0] sq;
    int r;
    fr = $urandom();
    sq = $urandom();
    push_vb(fr, m_tag, sq);
    for (int i = 0; i < len; i++) begin
      r  = $urandom_range(0, 99);
      fr = fr + 1;
      if (r < 3) begin
        sq = $urandom();
        push_vb(fr, m_tag, sq);
      end else if (r < 6) begin
        push_vb(fr, $urandom(), $urandom());
      end else if (r < 8) begin
        fr = $urandom();
        push_vb(fr, m_tag, sq);
      end else begin
        push_vb(fr, m_tag, sq);
      end
    end
  endtask

  task automatic random_phase(input int budget);
    int stop;
    int len;
    stop = n_gen + budget;
    while (n_gen < stop) begin
      repeat ($urandom_range(0, 2)) push_vb($urandom(), $urandom(), $urandom());
      len = $urandom_range(0, 32'(m_down) + 32'(m_up) + 2);
      // keep the phase close to its item budget
      if (len > stop - n_gen) len = stop - n_gen;
      flash_run(len);
    end
  endtask

  function automatic logic [7:0] pick_ramp();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(1, 24));
  endfunction

  initial begin
    m_tag       = EVENT_TAG_RST;
    m_down      = DOWN_FRAMES_RST;
    m_up        = UP_FRAMES_RST;
    m_floor     = FLOOR_ALPHA_RST;
    m_colour    = FLASH_COLOUR_RST;
    seen_seq    = '0;
    flash_start = '0;
    flash_on    = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // writes to unused indexes must leave the defaults alone
    for (int i = CFG_FLASH_COLOUR + 1; i < 2 ** CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), $urandom());

    // defaults: ignored events, wrap of the phase, ramp edges, restart
    push_vb(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_vb(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0005);
    push_vb(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    push_vb(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    push_vb(32'd10, 32'h0000_0000, 32'hFFFF_FFFF);
    push_vb(32'd11, 32'h0000_0000, 32'hFFFF_FFFF);
    push_vb(32'd30, 32'h0000_0000, 32'd7);
    push_vb(32'd41, 32'h0000_0000, 32'd7);
    push_vb(32'd89, 32'h0000_0000, 32'd7);
    push_vb(32'd90, 32'h0000_0000, 32'd7);
    push_vb(32'd91, 32'h0000_0000, 32'd7);

    // no ramps at all: first running frame is the last
    set_flash(32'hFFFF_FFFF, 8'd0, 8'd0, 8'd254, 24'hFF_FFFF);
    push_vb(32'd100, 32'hFFFF_FFFF, 32'd1);
    push_vb(32'd101, 32'hFFFF_FFFF, 32'd1);

    // floor at full alpha: black throughout
    set_flash(32'h1234_5678, 8'd3, 8'd0, 8'd255, 24'h80_40C0);
    push_vb(32'd5, 32'h1234_5678, 32'd2);
    push_vb(32'd6, 32'h1234_5678, 32'd2);
    push_vb(32'd7, 32'h1234_5678, 32'd2);
    push_vb(32'd8, 32'h1234_5678, 32'd2);

    // no downward ramp
    set_flash(32'hA5A5_5A5A, 8'd0, 8'd2, 8'd0, 24'h00_0000);
    push_vb(32'd200, 32'hA5A5_5A5A, 32'd3);
    push_vb(32'd201, 32'hA5A5_5A5A, 32'd3);
    push_vb(32'd202, 32'hA5A5_5A5A, 32'd3);

    set_flash($urandom(), 8'($urandom_range(1, 16)), 8'($urandom_range(1, 16)),
              8'($urandom_range(0, 254)), 24'($urandom()));
    random_phase(300);
    set_flash(32'hFFFF_FFFF, 8'd1, 8'd1, 8'd0, 24'hFF_FFFF);
    random_phase(200);
    set_flash(32'h0000_0000, 8'd255, 8'd255, 8'd254, 24'($urandom()));
    random_phase(300);
    set_flash($urandom(), 8'd0, 8'($urandom_range(1, 30)), 8'($urandom_range(0, 254)),
              24'($urandom()));
    random_phase(200);
    set_flash($urandom(), 8'($urandom_range(1, 30)), 8'd0, 8'd255, 24'($urandom()));
    random_phase(150);
    set_flash($urandom(), 8'd0, 8'd0, 8'($urandom_range(0, 254)), 24'($urandom()));
    random_phase(100);
    repeat (4) begin
      set_flash($urandom(), pick_ramp(), pick_ramp(), 8'($urandom_range(0, 254)),
                24'($urandom()));
      random_phase(150);
    end

    drain();
    if (n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
